### sv/kmp_pkg.sv
// Shared types and constants of the pattern matcher.
// Used by kmp_cell, kmp_pattern_matcher_unit and the testbench; depends on nothing else.
package kmp_pkg;

    // Kind of input word, carried in tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TEXT  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned LEN_CFG_W   = 5;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned OUT_POS_W   = 16;
    localparam int unsigned OUT_DATA_W  = 40;

    // Bit places of the result fields in the output tdata.
    localparam int unsigned OUT_MATCH_BIT = 0;
    localparam int unsigned OUT_FIRST_BIT = 17;

    // Control handed to every cell of the row.
    typedef struct packed {
        logic              start;
        logic              step;
        logic [BYTE_W-1:0] text_byte;
    } cell_ctrl_t;

endpackage

### sv/kmp_cell.sv
// One cell of the matching row: holds one pattern byte and one prefix-match bit.
// Depends on kmp_pkg for the cell control struct.
module kmp_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  kmp_pkg::cell_ctrl_t       ctrl,
    input  logic [kmp_pkg::BYTE_W-1:0] load_byte,
    input  logic                      carry_in,
    output logic                      hit,
    output logic                      hit_next
);

    logic [kmp_pkg::BYTE_W-1:0] pat_reg;
    logic                       hit_reg;

    // The prefix ending here extends the shorter prefix handed on by the left neighbour.
    assign hit_next = carry_in && (pat_reg == ctrl.text_byte);
    assign hit      = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            pat_reg <= load_byte;
            hit_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

### sv/kmp_pattern_matcher_unit.sv
// Top level of the pattern matcher: configuration, row of cells, position and result register.
// Depends on kmp_pkg and kmp_cell.
//
//  channel | signals                          | contents
//  s       | s_tvalid s_tready s_tdata s_tuser | text byte, operation, last byte on s_tlast
//  m       | m_tvalid m_tready m_tdata m_tlast | match and first-match fields, done on m_tlast
//  cfg     | cfg_write cfg_index cfg_data      | pattern low, pattern high, pattern length
//
// One word is accepted per clock unless stalled; its result is registered and shown on the following cycle.
// The rate is set by the single update of the cell row, in which every cell compares in parallel.
// A start word loads the pattern into the cells and clears all match bits and positions.
// Reset clears the pattern to one zero byte of length one; input stalls only on a full result slot.
module kmp_pattern_matcher_unit
#(
    parameter int unsigned PATTERN_MAX   = 16,
    parameter int unsigned POSITION_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // text_byte
    input  logic                                s_tuser,   // operation
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // match_here, match_start[15:0], first_found, first_start[15:0], zero fill
    output logic [kmp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast,   // search_done
    input  logic                                cfg_write,
    input  logic [kmp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kmp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int unsigned IDX_W  = $clog2(PATTERN_MAX);
    localparam int unsigned WIDE_W = (POSITION_BITS > kmp_pkg::OUT_POS_W) ?
                                     POSITION_BITS : kmp_pkg::OUT_POS_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [kmp_pkg::CFG_DATA_W-1:0] pattern_low_reg;
    logic [kmp_pkg::CFG_DATA_W-1:0] pattern_high_reg;
    logic [kmp_pkg::LEN_CFG_W-1:0]  length_reg;

    logic [LEN_W-1:0]          act_len_reg;
    logic [LEN_W-1:0]          act_len_next;
    logic [POSITION_BITS-1:0]  pos_reg;
    logic [POSITION_BITS-1:0]  pos_next;
    logic                      first_seen_reg;
    logic                      first_seen_next;
    logic [POSITION_BITS-1:0]  first_pos_reg;
    logic [POSITION_BITS-1:0]  first_pos_next;

    logic                              out_valid_reg;
    logic [kmp_pkg::OUT_DATA_W-1:0]    out_data_reg;
    logic [kmp_pkg::OUT_DATA_W-1:0]    out_data_next;
    logic                              out_last_reg;
    logic                              out_last_next;

    logic                      accept;
    kmp_pkg::cell_ctrl_t       ctrl;
    logic [PATTERN_MAX-1:0]    hit_vec;
    logic [PATTERN_MAX-1:0]    hit_next_vec;
    logic [IDX_W-1:0]          last_idx;
    logic                      match_here;
    logic [POSITION_BITS-1:0]  match_pos;
    logic [WIDE_W-1:0]         match_wide;
    logic [WIDE_W-1:0]         first_wide;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign ctrl.start     = accept && (s_tuser == kmp_pkg::OP_START);
    assign ctrl.step      = accept && (s_tuser == kmp_pkg::OP_TEXT);
    assign ctrl.text_byte = s_tdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            length_reg       <= kmp_pkg::LEN_CFG_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kmp_pkg::REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                kmp_pkg::REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                kmp_pkg::REG_PATTERN_LEN:  length_reg       <= cfg_data[kmp_pkg::LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Row of cells; each passes its prefix-match bit to its right neighbour.
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [kmp_pkg::BYTE_W-1:0] load_byte;
            logic                       carry_in;

            if (k < 8)
            begin : g_low
                assign load_byte = pattern_low_reg[k*8 +: 8];
            end
            else
            begin : g_high
                assign load_byte = pattern_high_reg[(k-8)*8 +: 8];
            end

            if (k == 0)
            begin : g_first
                assign carry_in = 1'b1;
            end
            else
            begin : g_rest
                assign carry_in = hit_vec[k-1];
            end

            kmp_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .load_byte (load_byte),
                .carry_in  (carry_in),
                .hit       (hit_vec[k]),
                .hit_next  (hit_next_vec[k])
            );
        end
    endgenerate

    always_comb
    begin
        if (length_reg == '0)
        begin
            act_len_next = LEN_W'(1);
        end
        else if (length_reg > kmp_pkg::LEN_CFG_W'(PATTERN_MAX))
        begin
            act_len_next = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            act_len_next = LEN_W'(length_reg);
        end
    end

    assign last_idx   = IDX_W'(act_len_reg - LEN_W'(1));
    assign match_here = hit_next_vec[last_idx];
    assign match_pos  = pos_reg - POSITION_BITS'(act_len_reg) + POSITION_BITS'(1);

    always_comb
    begin
        pos_next        = pos_reg;
        first_seen_next = first_seen_reg;
        first_pos_next  = first_pos_reg;
        if (ctrl.start)
        begin
            pos_next        = '0;
            first_seen_next = 1'b0;
            first_pos_next  = '0;
        end
        else if (ctrl.step)
        begin
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
            if (match_here && !first_seen_reg)
            begin
                first_seen_next = 1'b1;
                first_pos_next  = match_pos;
            end
        end
    end

    assign match_wide = WIDE_W'(match_here ? match_pos : '0);
    assign first_wide = WIDE_W'(first_pos_next);

    always_comb
    begin
        if (s_tuser == kmp_pkg::OP_START)
        begin
            out_data_next = '0;
            out_last_next = 1'b0;
        end
        else
        begin
            out_data_next = {6'b0, first_wide[kmp_pkg::OUT_POS_W-1:0], first_seen_next,
                             match_wide[kmp_pkg::OUT_POS_W-1:0], match_here};
            out_last_next = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_len_reg    <= LEN_W'(1);
            pos_reg        <= '0;
            first_seen_reg <= 1'b0;
            first_pos_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                act_len_reg <= act_len_next;
            end
            pos_reg        <= pos_next;
            first_seen_reg <= first_seen_next;
            first_pos_reg  <= first_pos_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A start word answers with an all-zero result on the next cycle.
    a_start_result : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> (m_tvalid && (m_tdata == '0) && !m_tlast))
        else $error("start word did not give a zero result");

    // A reported match always comes with the first-match flag set.
    a_match_first : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[kmp_pkg::OUT_MATCH_BIT]) |-> m_tdata[kmp_pkg::OUT_FIRST_BIT])
        else $error("match reported without first match flag");

    // The first-match flag and the text position only go back on a start word.
    a_first_kept : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_seen_reg) |-> $past(ctrl.start))
        else $error("first match flag cleared without start");

    a_pos_mono : assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg < $past(pos_reg)) |-> $past(ctrl.start))
        else $error("text position went back without start");

endmodule

### tb/kmp_pattern_matcher_unit_test.sv
// Self-checking testbench for kmp_pattern_matcher_unit: directed and random streams of
// start and text words, with a scoreboard that predicts every result of the search.
// Depends on kmp_pkg and the matcher RTL.
module kmp_pattern_matcher_unit_test;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_WORDS   = 1150;

    typedef struct packed {
        logic                          match_here;
        logic [kmp_pkg::OUT_POS_W-1:0] match_start;
        logic                          first_found;
        logic [kmp_pkg::OUT_POS_W-1:0] first_start;
        logic                          search_done;
    } match_result_t;

    class search_scoreboard;
        logic [kmp_pkg::CFG_DATA_W-1:0] reg_low;
        logic [kmp_pkg::CFG_DATA_W-1:0] reg_high;
        logic [kmp_pkg::LEN_CFG_W-1:0]  reg_len;
        logic [kmp_pkg::BYTE_W-1:0]     active_pattern [16];
        int                             active_len;
        int                             fallback [16];
        int                             matched;
        logic [15:0]                    position;
        logic                           first_seen;
        logic [15:0]                    first_pos;
        match_result_t                  pending [$];
        int                             errors;
        int                             results_seen;

        function new();
            reg_low = '0;
            reg_high = '0;
            reg_len = 5'd1;
            foreach (active_pattern[k])
            begin
                active_pattern[k] = '0;
                fallback[k] = 0;
            end
            active_len = 1;
            matched = 0;
            position = '0;
            first_seen = 1'b0;
            first_pos = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [kmp_pkg::CFG_INDEX_W-1:0] index,
                                logic [kmp_pkg::CFG_DATA_W-1:0] data);
            if (index == kmp_pkg::REG_PATTERN_LOW)
                reg_low = data;
            else if (index == kmp_pkg::REG_PATTERN_HIGH)
                reg_high = data;
            else if (index == kmp_pkg::REG_PATTERN_LEN)
                reg_len = data[kmp_pkg::LEN_CFG_W-1:0];
        endfunction

        // Samples the pattern and builds the longest prefix-suffix table.
        function void build_search();
            int j;
            for (int k = 0; k < 16; k++)
            begin
                if (k < 8)
                    active_pattern[k] = reg_low[k*8 +: 8];
                else
                    active_pattern[k] = reg_high[(k-8)*8 +: 8];
                fallback[k] = 0;
            end
            if (reg_len == 0)
                active_len = 1;
            else if (reg_len > 16)
                active_len = 16;
            else
                active_len = reg_len;
            j = 0;
            for (int q = 1; q < active_len; q++)
            begin
                while (j > 0 && active_pattern[j] != active_pattern[q])
                    j = fallback[j-1];
                if (active_pattern[j] == active_pattern[q])
                    j++;
                fallback[q] = j;
            end
        endfunction

        function void note_word(logic op, logic [kmp_pkg::BYTE_W-1:0] ch, logic last);
            match_result_t r;
            int m;
            int p;
            r = '0;
            if (op == kmp_pkg::OP_START)
            begin
                build_search();
                matched = 0;
                position = '0;
                first_seen = 1'b0;
                first_pos = '0;
            end
            else
            begin
                p = position;
                m = matched;
                if (m >= active_len)
                    m = 0;
                while (m > 0 && active_pattern[m] != ch)
                    m = fallback[m-1];
                if (active_pattern[m] == ch)
                    m++;
                if (m == active_len)
                begin
                    r.match_here = 1'b1;
                    r.match_start = 16'(p + 1 - active_len);
                    if (!first_seen)
                    begin
                        first_seen = 1'b1;
                        first_pos = r.match_start;
                    end
                    m = fallback[active_len-1];
                end
                matched = m;
                if (position != 16'hFFFF)
                    position++;
                r.first_found = first_seen;
                r.first_start = first_pos;
                r.search_done = last;
            end
            pending.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        task check_result(logic [kmp_pkg::OUT_DATA_W-1:0] data, logic done);
            match_result_t want;
            match_result_t got;
            results_seen++;
            got.match_here = data[kmp_pkg::OUT_MATCH_BIT];
            got.match_start = data[kmp_pkg::OUT_MATCH_BIT+1 +: kmp_pkg::OUT_POS_W];
            got.first_found = data[kmp_pkg::OUT_FIRST_BIT];
            got.first_start = data[kmp_pkg::OUT_FIRST_BIT+1 +: kmp_pkg::OUT_POS_W];
            got.search_done = done;
            if (pending.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing outstanding", results_seen));
            end
            else
            begin
                want = pending.pop_front();
                if (got.match_here != want.match_here)
                    report($sformatf("result %0d match_here %0d, wanted %0d",
                                     results_seen, got.match_here, want.match_here));
                if (got.match_start != want.match_start)
                    report($sformatf("result %0d match_start %0d, wanted %0d",
                                     results_seen, got.match_start, want.match_start));
                if (got.first_found != want.first_found)
                    report($sformatf("result %0d first_found %0d, wanted %0d",
                                     results_seen, got.first_found, want.first_found));
                if (got.first_start != want.first_start)
                    report($sformatf("result %0d first_start %0d, wanted %0d",
                                     results_seen, got.first_start, want.first_start));
                if (got.search_done != want.search_done)
                    report($sformatf("result %0d search_done %0d, wanted %0d",
                                     results_seen, got.search_done, want.search_done));
            end
        endtask
    endclass

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata = '0;
    logic                            s_tuser = kmp_pkg::OP_START;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [kmp_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tlast;
    logic                            cfg_write = 1'b0;
    logic [kmp_pkg::CFG_INDEX_W-1:0] cfg_index = kmp_pkg::REG_PATTERN_LOW;
    logic [kmp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    search_scoreboard sb = new();
    logic [127:0]                  cur_pattern = '0;
    logic [kmp_pkg::LEN_CFG_W-1:0] cur_len = 5'd1;
    bit                            no_idle = 1'b0;
    bit                            quiet_phase = 1'b0;
    int                            stall_left = 0;
    int                            items_sent = 0;
    int unsigned                   dead_cycles = 0;

    kmp_pattern_matcher_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0 && !no_idle)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else if (!no_idle && !quiet_phase && $urandom_range(0, 9) == 0)
        begin
            m_tready = 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_write)
            dead_cycles = 0;
        else
            dead_cycles++;
        if (dead_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(logic op, logic [7:0] ch, logic last);
        int gap;
        if (!no_idle && !quiet_phase && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = ch;
        s_tlast = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(op, ch, last);
        items_sent++;
    endtask

    task automatic send_text(logic [7:0] ch);
        send_word(kmp_pkg::OP_TEXT, ch, $urandom_range(0, 31) == 0);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [kmp_pkg::CFG_INDEX_W-1:0] index,
                             logic [kmp_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data = data;
        @(posedge clk);
        sb.write_reg(index, data);
        if (index == kmp_pkg::REG_PATTERN_LOW)
            cur_pattern[63:0] = data;
        else if (index == kmp_pkg::REG_PATTERN_HIGH)
            cur_pattern[127:64] = data;
        else if (index == kmp_pkg::REG_PATTERN_LEN)
            cur_len = data[kmp_pkg::LEN_CFG_W-1:0];
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic run_directed();
        logic [7:0] text [8];
        text = '{8'h61, 8'h61, 8'h62, 8'h61, 8'h61, 8'h62, 8'h61, 8'h61};
        // Before any start the pattern is a single zero byte.
        send_word(kmp_pkg::OP_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::OP_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::OP_TEXT, 8'h00, 1'b1);
        wait_idle();
        write_reg(kmp_pkg::REG_PATTERN_LOW, 64'h0000_0061_6162_6161);
        write_reg(kmp_pkg::REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(kmp_pkg::REG_PATTERN_LEN, 64'd5);
        // The new pattern is not in force until the next start.
        send_word(kmp_pkg::OP_TEXT, 8'h00, 1'b0);
        send_word(kmp_pkg::OP_START, 8'hFF, 1'b1);
        foreach (text[k])
            send_word(kmp_pkg::OP_TEXT, text[k], k == 7);
        wait_idle();
        write_reg(kmp_pkg::REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(kmp_pkg::REG_PATTERN_LEN, 64'd0);
        send_word(kmp_pkg::OP_START, 8'h00, 1'b0);
        send_word(kmp_pkg::OP_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::OP_TEXT, 8'hFF, 1'b0);
        send_word(kmp_pkg::OP_TEXT, 8'h00, 1'b1);
    endtask

    task automatic run_phase(int n_text);
        logic [7:0]  sym [2];
        logic [127:0] pat;
        int          use_len;
        int          plen;
        int          sent;
        int          pick;
        wait_idle();
        quiet_phase = ($urandom_range(0, 3) == 0);
        sym[0] = 8'($urandom);
        sym[1] = 8'($urandom);
        for (int k = 0; k < 16; k++)
            pat[k*8 +: 8] = ($urandom_range(0, 3) != 0) ? sym[$urandom_range(0, 1)]
                                                         : 8'($urandom);
        if ($urandom_range(0, 4) != 0)
            write_reg(kmp_pkg::REG_PATTERN_LOW, pat[63:0]);
        if ($urandom_range(0, 4) != 0)
            write_reg(kmp_pkg::REG_PATTERN_HIGH, pat[127:64]);
        if ($urandom_range(0, 6) != 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_reg(kmp_pkg::REG_PATTERN_LEN,
                          64'(($urandom_range(0, 1) == 0) ? 0 : 16));
            else if (pick == 1)
                write_reg(kmp_pkg::REG_PATTERN_LEN, 64'($urandom_range(17, 31)));
            else if (pick < 6)
                write_reg(kmp_pkg::REG_PATTERN_LEN, 64'($urandom_range(1, 5)));
            else
                write_reg(kmp_pkg::REG_PATTERN_LEN, 64'($urandom_range(1, 16)));
        end
        if ($urandom_range(0, 7) != 0)
            send_word(kmp_pkg::OP_START, 8'($urandom), 1'($urandom));
        use_len = (cur_len == 0) ? 1 : ((cur_len > 16) ? 16 : cur_len);
        sent = 0;
        while (sent < n_text)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                plen = ($urandom_range(0, 2) == 0) ? use_len : $urandom_range(1, use_len);
                for (int k = 0; k < plen; k++)
                    send_text(cur_pattern[k*8 +: 8]);
                sent += plen;
            end
            else if (pick < 88)
            begin
                send_text(cur_pattern[$urandom_range(0, use_len - 1)*8 +: 8]);
                sent++;
            end
            else if (pick < 97)
            begin
                send_text(8'($urandom));
                sent++;
            end
            else
            begin
                send_word(kmp_pkg::OP_START, 8'($urandom), 1'($urandom));
            end
        end
        send_word(kmp_pkg::OP_TEXT, 8'($urandom), 1'b1);
    endtask

    initial
    begin
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        while (items_sent < RANDOM_WORDS)
            run_phase($urandom_range(20, 60));
        no_idle = 1'b1;
        repeat (3)
            run_phase($urandom_range(20, 60));
        wait_idle();
        repeat (10)
            @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
sv/kmp_pkg.sv
sv/kmp_cell.sv
sv/kmp_pattern_matcher_unit.sv
tb/kmp_pattern_matcher_unit_test.sv
